@@ rtl/core/tlvrfe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlvrfe_pkg
// Shared types, tag codes and field kinds for the tag-length-value record
// field extractor.
// ----------------------------------------------------------------------------
package tlvrfe_pkg;

  localparam int IMAGE_BYTES_DEF = 128;
  localparam int TEXT_BYTES_DEF  = 16;

  // Record tags
  localparam logic [7:0] TAG_CLEI     = 8'h1a;
  localparam logic [7:0] TAG_DATE     = 8'h17;
  localparam logic [7:0] TAG_SERIAL   = 8'h16;
  localparam logic [7:0] TAG_PART     = 8'h15;
  localparam logic [7:0] TAG_DIR      = 8'h05;
  localparam logic [7:0] TAG_TYPE     = 8'h01;
  localparam logic [7:0] TAG_CHECKSUM = 8'h00;

  // Field kinds
  localparam logic [2:0] KIND_CLEI     = 3'd0;
  localparam logic [2:0] KIND_DATE     = 3'd1;
  localparam logic [2:0] KIND_SERIAL   = 3'd2;
  localparam logic [2:0] KIND_PART     = 3'd3;
  localparam logic [2:0] KIND_DIR      = 3'd4;
  localparam logic [2:0] KIND_TYPE     = 3'd5;
  localparam logic [2:0] KIND_CHECKSUM = 3'd6;

  // Result events
  localparam logic [1:0] EV_VALUE = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_HALT  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [2:0]  field_kind;
    logic [3:0]  byte_pos;
    logic [7:0]  value_byte;
    logic        record_last;
    logic [31:0] directive_word;
    logic        image_done;
  } out_req_t;

  typedef struct packed {
    logic       known;
    logic [2:0] kind;
  } tag_lookup_t;

  function automatic tag_lookup_t lookup_tag(input logic [7:0] tag);
    tag_lookup_t res;
    res.known = 1'b1;
    res.kind  = KIND_CLEI;
    unique case (tag)
      TAG_CLEI:     res.kind = KIND_CLEI;
      TAG_DATE:     res.kind = KIND_DATE;
      TAG_SERIAL:   res.kind = KIND_SERIAL;
      TAG_PART:     res.kind = KIND_PART;
      TAG_DIR:      res.kind = KIND_DIR;
      TAG_TYPE:     res.kind = KIND_TYPE;
      TAG_CHECKSUM: res.kind = KIND_CHECKSUM;
      default:      res.known = 1'b0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tlv_record_field_extractor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_record_field_extractor
// Parses tag, length, value records from an identity-memory image streamed
// one byte per request and reports kept value bytes and record events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one image byte per
//   request; set image_start on the first byte of each image to restart the
//   parser. Result channel (out_valid / out_stall / out_data) carries at most
//   one result per input byte: a kept value byte, an empty record or an
//   unknown-tag halt. Known tag bytes, nonzero length bytes, excess value bytes and
//   bytes after the image end or a halt produce nothing.
//   A result is registered in the output register, or the skid register if held.
//   Throughput: one byte per cycle while in_stall is low, set by the single
//   parse stage that updates the parser state and a result register together.
//   Stall: a result waiting under out_stall stays on the port while the next
//   byte is still taken; its result goes to a one-entry skid register.
//   in_stall rises only while that skid register is occupied.
//   Reset: parser returns to expect-tag at image byte 0, both result
//   registers are emptied.
// ----------------------------------------------------------------------------
module tlv_record_field_extractor #(
  parameter int IMAGE_BYTES = tlvrfe_pkg::IMAGE_BYTES_DEF,
  parameter int TEXT_BYTES  = tlvrfe_pkg::TEXT_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tlvrfe_pkg::in_req_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tlvrfe_pkg::out_req_t      out_data
);

  // Byte counter width covers image positions 0 .. IMAGE_BYTES-1.
  localparam int BI_W   = $clog2(IMAGE_BYTES);
  // Value counter saturates at the keep limit; keep at least 4 bits for byte_pos.
  localparam int VI_RAW = $clog2(TEXT_BYTES) + 1;
  localparam int VI_W   = (VI_RAW > 4) ? VI_RAW : 4;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_VAL,
    PH_HALT
  } phase_t;

  // Parser state
  phase_t            phase_r, phase_nxt;
  logic [BI_W-1:0]   bidx_r, bidx_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [VI_W-1:0]   vi_r, vi_nxt;
  logic [31:0]       word_r, word_nxt;

  // Result registers
  logic                 out_valid_r;
  tlvrfe_pkg::out_req_t out_r;
  logic                 skid_valid_r;
  tlvrfe_pkg::out_req_t skid_r;

  // Effective state after an image start
  phase_t            eff_phase;
  logic [BI_W-1:0]   eff_bidx;
  logic [2:0]        eff_kind;
  logic [7:0]        eff_rem;
  logic [VI_W-1:0]   eff_vi;
  logic [31:0]       eff_word;

  logic                   accept;
  logic                   produce;
  logic                   last_byte;
  tlvrfe_pkg::out_req_t   res;
  tlvrfe_pkg::tag_lookup_t look;
  logic [7:0]             rem_dec;
  logic [VI_W-1:0]        lim;
  logic [VI_W-1:0]        vi_inc;
  logic                   keep;
  logic [31:0]            word_upd;

  function automatic logic [VI_W-1:0] keep_limit(input logic [2:0] kind);
    logic [VI_W-1:0] l;
    if (kind <= tlvrfe_pkg::KIND_PART) begin
      l = VI_W'(TEXT_BYTES - 1);
    end else if (kind == tlvrfe_pkg::KIND_DIR) begin
      l = VI_W'(4);
    end else begin
      l = VI_W'(1);
    end
    return l;
  endfunction

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Apply image start before parsing the byte.
  always_comb begin
    if (in_data.image_start) begin
      eff_phase = PH_TAG;
      eff_bidx  = '0;
      eff_kind  = tlvrfe_pkg::KIND_CLEI;
      eff_rem   = '0;
      eff_vi    = '0;
      eff_word  = '0;
    end else begin
      eff_phase = phase_r;
      eff_bidx  = bidx_r;
      eff_kind  = kind_r;
      eff_rem   = rem_r;
      eff_vi    = vi_r;
      eff_word  = word_r;
    end
  end

  assign last_byte = (eff_bidx == BI_W'(IMAGE_BYTES - 1));
  assign look      = tlvrfe_pkg::lookup_tag(in_data.data_byte);
  assign rem_dec   = eff_rem - 8'd1;
  assign lim       = keep_limit(eff_kind);
  assign vi_inc    = eff_vi + VI_W'(1);
  assign keep      = (eff_vi < lim);

  // Place a directives byte, most significant byte first.
  always_comb begin
    word_upd = eff_word;
    unique case (eff_vi[1:0])
      2'd0: word_upd[31:24] = in_data.data_byte;
      2'd1: word_upd[23:16] = in_data.data_byte;
      2'd2: word_upd[15:8]  = in_data.data_byte;
      2'd3: word_upd[7:0]   = in_data.data_byte;
    endcase
  end

  // Parse one byte.
  always_comb begin
    phase_nxt = eff_phase;
    bidx_nxt  = eff_bidx;
    kind_nxt  = eff_kind;
    rem_nxt   = eff_rem;
    vi_nxt    = eff_vi;
    word_nxt  = eff_word;
    produce   = 1'b0;
    res       = '0;
    res.image_done = last_byte;

    unique case (eff_phase)
      PH_TAG: begin
        if (!look.known) begin
          res.event_res = tlvrfe_pkg::EV_HALT;
          produce       = 1'b1;
          phase_nxt     = PH_HALT;
        end else begin
          kind_nxt  = look.kind;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        rem_nxt  = in_data.data_byte;
        vi_nxt   = '0;
        word_nxt = '0;
        if (in_data.data_byte == 8'd0) begin
          res.event_res   = tlvrfe_pkg::EV_EMPTY;
          res.field_kind  = eff_kind;
          res.record_last = 1'b1;
          produce         = 1'b1;
          phase_nxt       = PH_TAG;
        end else begin
          phase_nxt = PH_VAL;
        end
      end
      PH_VAL: begin
        rem_nxt = rem_dec;
        if (keep) begin
          if (eff_kind == tlvrfe_pkg::KIND_DIR) begin
            word_nxt = word_upd;
          end
          res.event_res   = tlvrfe_pkg::EV_VALUE;
          res.field_kind  = eff_kind;
          res.byte_pos    = eff_vi[3:0];
          res.value_byte  = in_data.data_byte;
          res.record_last = (rem_dec == 8'd0) || (vi_inc == lim) || last_byte;
          if ((eff_kind == tlvrfe_pkg::KIND_DIR) && res.record_last) begin
            res.directive_word = word_upd;
          end
          produce = 1'b1;
          // Saturate at the keep limit; excess bytes are dropped.
          vi_nxt  = vi_inc;
        end
        if (rem_dec == 8'd0) begin
          phase_nxt = PH_TAG;
        end
      end
      PH_HALT: begin
        produce = 1'b0;
      end
    endcase

    if (eff_phase != PH_HALT) begin
      if (last_byte) begin
        phase_nxt = PH_HALT;
      end else begin
        bidx_nxt = BI_W'(eff_bidx + 1'b1);
      end
    end

    produce = produce && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TAG;
      bidx_r       <= '0;
      kind_r       <= tlvrfe_pkg::KIND_CLEI;
      rem_r        <= '0;
      vi_r         <= '0;
      word_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        bidx_r  <= bidx_nxt;
        kind_r  <= kind_nxt;
        rem_r   <= rem_nxt;
        vi_r    <= vi_nxt;
        word_r  <= word_nxt;
      end
      if (!out_valid_r || !out_stall) begin
        // Output moves: drain the skid first, else take the new result.
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (produce) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (produce) begin
        // Output held: park the new result.
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output is empty");

  a_word_only_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.field_kind != tlvrfe_pkg::KIND_DIR))
      |-> (out_r.directive_word == 32'd0))
    else $error("directives word shown on a non-directives result");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (phase_r == PH_HALT) && !in_data.image_start) |=> (phase_r == PH_HALT))
    else $error("parser left halt without an image start");
`endif

endmodule
`default_nettype wire
